// ===== rtl/zpvd_pkg.sv =====
// ----------------------------------------------------------------------------
// zpvd_pkg
// Shared types, constants and functions of the zigzag prefix varint decoder.
// ----------------------------------------------------------------------------
package zpvd_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned WordW  = 32;
  localparam int unsigned LenW   = 3;

  // Byte counts of each code form, escape byte included
  localparam logic [LenW-1:0] Len1   = 3'd1;
  localparam logic [LenW-1:0] Len2   = 3'd2;
  localparam logic [LenW-1:0] Len3   = 3'd3;
  localparam logic [LenW-1:0] Len4   = 3'd4;
  localparam logic [LenW-1:0] LenEsc = 3'd5;

  typedef struct packed {
    logic signed [WordW-1:0] value;
    logic [LenW-1:0]         code_length;
  } result_t;

  // Sign in the low bit: odd words map to the complement of the halved word
  function automatic logic [WordW-1:0] unzigzag(input logic [WordW-1:0] v);
    unzigzag = {1'b0, v[WordW-1:1]} ^ {WordW{v[0]}};
  endfunction

endpackage

// ===== rtl/zigzag_prefix_varint_decoder_top.sv =====
// ----------------------------------------------------------------------------
// zigzag_prefix_varint_decoder_top
// Decodes prefix-coded, zigzag-signed 32-bit integers from a byte stream.
// ----------------------------------------------------------------------------
//  channel | direction | signals
//  in      | sink      | in_valid_i, in_ready_o, byte_in_i[7:0]
//  out     | source    | out_valid_o, out_ready_i, value_o[31:0], code_length_o[2:0]
//
//  One byte per cycle sustained unless a result is held; a byte is decoded
//  from the input reg and its result, if any, shows on the next cycle from the result reg.
//  A code of n bytes gives one result, on its last byte.
//  Reset empties both registers and waits for a lead byte.
//  A held result stalls the decoder, whether or not the next byte would
//  finish a code; the input register takes at most one more byte and then
//  in_ready_o falls until the result beat goes out.
// ----------------------------------------------------------------------------
module zigzag_prefix_varint_decoder_top
  import zpvd_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [ByteW-1:0]        byte_in_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic signed [WordW-1:0] value_o,
  output logic [LenW-1:0]         code_length_o
);

  logic             in_valid_q;
  logic [ByteW-1:0] byte_q;
  logic             advance;
  logic             free;
  logic             result_valid;
  result_t          result;

  assign advance    = in_valid_q & free;
  assign in_ready_o = ~in_valid_q | free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      byte_q <= byte_in_i;
    end
  end

  zpvd_decode u_decode (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .advance_i      (advance),
    .byte_i         (byte_q),
    .result_valid_o (result_valid),
    .result_o       (result)
  );

  zpvd_out_stage u_out (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (result_valid),
    .result_i      (result),
    .free_o        (free),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .value_o       (value_o),
    .code_length_o (code_length_o)
  );

  a_hold_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !advance |=> in_valid_q && $stable(byte_q))
    else $error("input beat lost while stalled");

  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> in_valid_q && !out_ready_i && out_valid_o)
    else $error("input stalled without a held result");

endmodule

// ===== rtl/zpvd_decode.sv =====
// ----------------------------------------------------------------------------
// zpvd_decode
// Code state and word assembly: one byte per advance, result on last byte.
// ----------------------------------------------------------------------------
module zpvd_decode
  import zpvd_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 advance_i,
  input  logic [ByteW-1:0]     byte_i,
  output logic                 result_valid_o,
  output result_t              result_o
);

  logic [LenW-1:0]  bytes_left_q, bytes_left_d;
  logic [WordW-1:0] acc_q, acc_d;
  logic [LenW-1:0]  len_q, len_d;
  logic             emit;
  logic [LenW-1:0]  emit_len;

  always_comb begin
    bytes_left_d = bytes_left_q;
    acc_d        = acc_q;
    len_d        = len_q;
    emit         = 1'b0;
    emit_len     = len_q;
    if (bytes_left_q != '0) begin
      // continuation: shift in all eight bits, no lead check
      acc_d        = {acc_q[WordW-ByteW-1:0], byte_i};
      bytes_left_d = bytes_left_q - 3'd1;
      emit         = (bytes_left_q == 3'd1);
    end else begin
      priority casez (byte_i)
        8'b0???????: begin
          acc_d    = {{(WordW-7){1'b0}}, byte_i[6:0]};
          len_d    = Len1;
          emit     = 1'b1;
          emit_len = Len1;
        end
        8'b10??????: begin
          acc_d        = {{(WordW-6){1'b0}}, byte_i[5:0]};
          bytes_left_d = 3'd1;
          len_d        = Len2;
        end
        8'b110?????: begin
          acc_d        = {{(WordW-5){1'b0}}, byte_i[4:0]};
          bytes_left_d = 3'd2;
          len_d        = Len3;
        end
        8'b1110????: begin
          acc_d        = {{(WordW-4){1'b0}}, byte_i[3:0]};
          bytes_left_d = 3'd3;
          len_d        = Len4;
        end
        default: begin
          // escape: drop the lead byte, four full bytes follow
          acc_d        = '0;
          bytes_left_d = 3'd4;
          len_d        = LenEsc;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bytes_left_q <= '0;
      acc_q        <= '0;
      len_q        <= '0;
    end else if (advance_i) begin
      bytes_left_q <= bytes_left_d;
      acc_q        <= acc_d;
      len_q        <= len_d;
    end
  end

  assign result_valid_o       = advance_i & emit;
  assign result_o.value       = unzigzag(acc_d);
  assign result_o.code_length = emit_len;

  a_left_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bytes_left_q <= 3'd4)
    else $error("bytes_left out of range");

  a_last_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance_i && bytes_left_q == 3'd1 |=> bytes_left_q == '0)
    else $error("code did not close on its last byte");

  a_cont_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bytes_left_q != '0 |-> len_q >= Len2 && len_q <= LenEsc)
    else $error("multi-byte code with bad length");

endmodule

// ===== rtl/zpvd_out_stage.sv =====
// ----------------------------------------------------------------------------
// zpvd_out_stage
// Result register on the output channel.
// ----------------------------------------------------------------------------
module zpvd_out_stage
  import zpvd_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    load_i,
  input  result_t                 result_i,
  output logic                    free_o,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic signed [WordW-1:0] value_o,
  output logic [LenW-1:0]         code_length_o
);

  logic    valid_q, valid_d;
  result_t data_q;

  assign free_o  = ~valid_q | out_ready_i;
  assign valid_d = load_i | (valid_q & ~out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= result_i;
    end
  end

  assign out_valid_o   = valid_q;
  assign value_o       = data_q.value;
  assign code_length_o = data_q.code_length;

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |-> free_o)
    else $error("result register overwritten while held");

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Testbench of zigzag_prefix_varint_decoder_top: a byte stream of directed and
// random prefix codes goes in, and each decoded word is checked on the fly
// against a cycle-free decoder kept in step with every byte taken.
// ----------------------------------------------------------------------------
module tb;
  import zpvd_pkg::*;

  localparam int unsigned StallLimit   = 2000;
  localparam int unsigned RxHoldCycles = 160;
  localparam int unsigned StreamBytes  = 1300;
  localparam int unsigned SettleCycles = 20;

  // Lead byte tags, top bits of the first byte of a code
  localparam logic [1:0] LeadTwo   = 2'b10;
  localparam logic [2:0] LeadThree = 3'b110;
  localparam logic [3:0] LeadFour  = 4'b1110;
  localparam logic [3:0] LeadEsc   = 4'b1111;

  typedef struct {
    logic [ByteW-1:0] data;
    int unsigned      gap;
    bit               drain;
  } stream_beat_t;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    in_valid_i = 1'b0;
  logic                    in_ready_o;
  logic [ByteW-1:0]        byte_in_i = '0;
  logic                    out_valid_o;
  logic                    out_ready_i = 1'b0;
  logic signed [WordW-1:0] value_o;
  logic [LenW-1:0]         code_length_o;

  stream_beat_t tx_bytes[$];
  result_t      expected_words[$];
  int unsigned  fail_count = 0;

  // decoder state, mirrors the block
  logic [LenW-1:0]  dec_left = '0;
  logic [LenW-1:0]  dec_len = '0;
  logic [WordW-1:0] dec_acc = '0;

  // stimulus shaping
  bit burst_mode;
  bit drain_next;

  zigzag_prefix_varint_decoder_top DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .byte_in_i     (byte_in_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .value_o       (value_o),
    .code_length_o (code_length_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  task automatic decode_byte(input logic [ByteW-1:0] b);
    result_t word;
    bit      done;
    done = 1'b0;
    if (dec_left != 0) begin
      dec_acc  = {dec_acc[WordW-ByteW-1:0], b};
      dec_left = dec_left - 3'd1;
      done     = (dec_left == 0);
    end else if (!b[7]) begin
      dec_acc = {25'd0, b[6:0]};
      dec_len = Len1;
      done    = 1'b1;
    end else if (b[7:6] == LeadTwo) begin
      dec_acc  = {26'd0, b[5:0]};
      dec_left = 3'd1;
      dec_len  = Len2;
    end else if (b[7:5] == LeadThree) begin
      dec_acc  = {27'd0, b[4:0]};
      dec_left = 3'd2;
      dec_len  = Len3;
    end else if (b[7:4] == LeadFour) begin
      dec_acc  = {28'd0, b[3:0]};
      dec_left = 3'd3;
      dec_len  = Len4;
    end else begin
      // escape: drop the low nibble, four full bytes follow
      dec_acc  = '0;
      dec_left = 3'd4;
      dec_len  = LenEsc;
    end
    if (done) begin
      word.value       = dec_acc[0] ? ~(dec_acc >> 1) : (dec_acc >> 1);
      word.code_length = dec_len;
      expected_words.push_back(word);
    end
  endtask

  function automatic logic [ByteW-1:0] pick_byte();
    case ($urandom_range(0, 7))
      0:       pick_byte = 8'h00;
      1:       pick_byte = 8'hFF;
      default: pick_byte = ByteW'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic queue_byte(input logic [ByteW-1:0] b);
    stream_beat_t beat;
    beat.data  = b;
    beat.gap   = burst_mode ? 0 : $urandom_range(0, 13);
    beat.drain = drain_next;
    drain_next = 1'b0;
    tx_bytes.push_back(beat);
  endtask

  // well-formed code of the given length with random payload
  task automatic queue_code(input logic [LenW-1:0] len);
    logic [ByteW-1:0] lead;
    lead = pick_byte();
    case (len)
      Len1:    queue_byte({1'b0, lead[6:0]});
      Len2:    queue_byte({LeadTwo, lead[5:0]});
      Len3:    queue_byte({LeadThree, lead[4:0]});
      Len4:    queue_byte({LeadFour, lead[3:0]});
      default: queue_byte({LeadEsc, lead[3:0]});
    endcase
    for (int i = 1; i < len; i++) queue_byte(pick_byte());
  endtask

  // driver: take beats at the rising edge, offer the next at the falling edge
  logic        in_beat = 1'b0;
  logic        next_valid;
  logic [7:0]  next_data;
  bit          gap_armed = 1'b0;
  int unsigned gap_left = 0;

  always @(posedge clk_i) begin
    in_beat <= rst_ni && in_valid_i && in_ready_o;
    if (rst_ni && in_valid_i && in_ready_o) decode_byte(byte_in_i);
  end

  always @(negedge clk_i) begin
    next_valid = in_valid_i && !in_beat;
    next_data  = byte_in_i;
    if (!next_valid && rst_ni && tx_bytes.size() != 0) begin
      if (!gap_armed) begin
        gap_left  = tx_bytes[0].gap;
        gap_armed = 1'b1;
      end
      if (gap_left != 0) begin
        gap_left--;
      end else if (!tx_bytes[0].drain || expected_words.size() == 0) begin
        next_data  = tx_bytes[0].data;
        next_valid = 1'b1;
        void'(tx_bytes.pop_front());
        gap_armed  = 1'b0;
      end
    end
    in_valid_i <= next_valid;
    byte_in_i  <= next_data;
  end

  // monitor: check beats at the rising edge, steer ready at the falling edge
  logic        out_beat = 1'b0;
  bit          rx_stalls = 1'b1;
  int unsigned rx_wait = 0;
  int unsigned rx_beats = 0;

  always @(posedge clk_i) begin
    result_t want;
    out_beat <= rst_ni && out_valid_o && out_ready_i;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_words.size() == 0) begin
        $error("value: unexpected result %0d, length %0d, nothing pending",
               value_o, code_length_o);
        fail_count++;
      end else begin
        want = expected_words.pop_front();
        if (value_o !== want.value) begin
          $error("value: expected %0d, actual %0d", want.value, value_o);
          fail_count++;
        end
        if (code_length_o !== want.code_length) begin
          $error("code_length: expected %0d, actual %0d", want.code_length,
                 code_length_o);
          fail_count++;
        end
      end
    end
  end

  always @(negedge clk_i) begin
    if (out_beat) begin
      rx_beats++;
      // long hold-offs so that the block backs up into its input
      if (rx_beats == 25 || rx_beats == 150 || rx_beats == 350) rx_wait = RxHoldCycles;
      else rx_wait = rx_stalls ? $urandom_range(0, 13) : 0;
      if ($urandom_range(0, 39) == 0) rx_stalls = !rx_stalls;
    end
    if (rx_wait != 0) begin
      rx_wait--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  initial begin : watchdog
    int unsigned idle;
    idle = 0;
    while (idle < StallLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle = 0;
      else idle++;
    end
    $display("zigzag_prefix_varint_decoder_top verification failed");
    $finish;
  end

  initial begin
    int unsigned phase_left;
    burst_mode = 1'b0;
    drain_next = 1'b0;

    // short codes at both payload extremes
    queue_byte(8'h00);
    queue_byte(8'h7F);
    queue_byte(8'h01);
    queue_byte(8'hBF); queue_byte(8'hFF);
    // continuation byte that looks like an escape lead
    queue_byte(8'h80); queue_byte(8'hF0);
    queue_byte(8'hC0); queue_byte(8'h00); queue_byte(8'h00);
    queue_byte(8'hEF); queue_byte(8'hFF); queue_byte(8'hFF); queue_byte(8'hFF);
    // escape codes: most negative and most positive word
    queue_byte(8'hFF); queue_byte(8'hFF); queue_byte(8'hFF); queue_byte(8'hFF);
    queue_byte(8'hFF);
    queue_byte(8'hF0); queue_byte(8'hFF); queue_byte(8'hFF); queue_byte(8'hFF);
    queue_byte(8'hFE);

    // random phases: mostly whole codes, some stray bytes
    while (tx_bytes.size() < StreamBytes) begin
      burst_mode = ($urandom_range(0, 2) == 0);
      drain_next = 1'b1;
      phase_left = $urandom_range(60, 250);
      while (phase_left != 0 && tx_bytes.size() < StreamBytes) begin
        if ($urandom_range(0, 9) == 0) queue_byte(pick_byte());
        else queue_code(LenW'($urandom_range(1, 5)));
        phase_left--;
      end
    end

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (tx_bytes.size() != 0 || in_valid_i) @(posedge clk_i);
    while (expected_words.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);

    if (fail_count == 0) begin
      $display("zigzag_prefix_varint_decoder_top verification clean");
    end else begin
      $display("zigzag_prefix_varint_decoder_top verification failed");
    end
    $finish;
  end

endmodule
